FILE: design/pdug_pkg.sv
package pdug_pkg;

    // Field widths fixed by the interface
    localparam int SIZE_W  = 13;
    localparam int CHAN_W  = 8;
    localparam int COORD_W = 13;
    localparam int INDEX_W = 2;

    // Default image size limits
    localparam int MAX_COLS_DEF = 4096;
    localparam int MAX_ROWS_DEF = 4096;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_IMAGE_COLS  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_ROWS  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_GRAY_ENABLE = 2'd2;

    // Luma weights in 16-bit fixed point, summing to 65536
    localparam int LUMA_PROD_W = 24;
    localparam logic [LUMA_PROD_W-1:0] W_RED   = 24'd13933;
    localparam logic [LUMA_PROD_W-1:0] W_GREEN = 24'd46871;
    localparam logic [LUMA_PROD_W-1:0] W_BLUE  = 24'd4732;

    // Position inside the 2x2 output block
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd3;

endpackage

FILE: design/pixel_double_upscale_gray.sv
// Nearest-neighbor 2x upscaler with optional luma gray conversion.
//
// Input channel (in_valid / in_stall): one source RGB pixel per transaction,
// in raster order. Output channel (out_valid / out_stall): four transactions
// per source pixel, the 2x2 destination block in the order (0,0), (0,1),
// (1,0), (1,1), each with its destination row and column; block_last marks
// the fourth. With gray_enable set, all three channels carry
// Y = (13933R + 46871G + 4732B) >> 16.
//
// A pixel passes from the hold register into the single output register,
// which takes one result per cycle while the receiver does not stall.
// A pixel sits in a hold register while its four results go out; the
// next pixel is accepted in the same cycle the fourth result moves into
// the output register, so the output stream has no gaps while the source
// keeps up.
//
// When the receiver stalls, the output register holds its transaction and
// the hold register stops advancing; in_stall rises once the hold register
// is occupied. Reset empties both registers, returns the position to (0,0)
// and sets image_cols = 1, image_rows = 1, gray_enable = 0. Configuration
// writes (cfg_we) take effect at the next clock edge, with no read-back.
module pixel_double_upscale_gray #(
    parameter int MAX_COLS = pdug_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = pdug_pkg::MAX_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write port
    input  logic                          cfg_we,
    input  logic [pdug_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [pdug_pkg::SIZE_W-1:0]   cfg_data,

    // source pixel channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pdug_pkg::CHAN_W-1:0]   red,
    input  logic [pdug_pkg::CHAN_W-1:0]   green,
    input  logic [pdug_pkg::CHAN_W-1:0]   blue,

    // destination pixel channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pdug_pkg::COORD_W-1:0]  out_row,
    output logic [pdug_pkg::COORD_W-1:0]  out_col,
    output logic [pdug_pkg::CHAN_W-1:0]   out_red,
    output logic [pdug_pkg::CHAN_W-1:0]   out_green,
    output logic [pdug_pkg::CHAN_W-1:0]   out_blue,
    output logic                          block_last
);

    // Position counters hold values below the size limit; the incremented
    // value needs one bit more so it can reach the limit itself.
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CCMP_W  = (COL_W + 1 > pdug_pkg::SIZE_W) ? COL_W + 1 : pdug_pkg::SIZE_W;
    localparam int RCMP_W  = (ROW_W + 1 > pdug_pkg::SIZE_W) ? ROW_W + 1 : pdug_pkg::SIZE_W;

    // configuration registers
    logic [pdug_pkg::SIZE_W-1:0]   cols_reg;
    logic [pdug_pkg::SIZE_W-1:0]   rows_reg;
    logic                          gray_reg;

    // source position
    logic [COL_W-1:0]              col_pos_reg;
    logic [COL_W-1:0]              col_pos_next;
    logic [ROW_W-1:0]              row_pos_reg;
    logic [ROW_W-1:0]              row_pos_next;

    // hold register: the pixel whose 2x2 block is being emitted
    logic                          hold_valid_reg;
    logic                          hold_valid_next;
    logic [pdug_pkg::CHAN_W-1:0]   hold_red_reg;
    logic [pdug_pkg::CHAN_W-1:0]   hold_green_reg;
    logic [pdug_pkg::CHAN_W-1:0]   hold_blue_reg;
    logic [COL_W-1:0]              hold_col_reg;
    logic [ROW_W-1:0]              hold_row_reg;
    logic [pdug_pkg::PHASE_W-1:0]  phase_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [pdug_pkg::COORD_W-1:0]  out_row_reg;
    logic [pdug_pkg::COORD_W-1:0]  out_col_reg;
    logic [pdug_pkg::CHAN_W-1:0]   out_red_reg;
    logic [pdug_pkg::CHAN_W-1:0]   out_green_reg;
    logic [pdug_pkg::CHAN_W-1:0]   out_blue_reg;
    logic                          out_last_reg;

    // handshake and datapath
    logic                          in_accept;
    logic                          out_load;
    logic                          hold_done;
    logic [CCMP_W-1:0]             cols_eff;
    logic [RCMP_W-1:0]             rows_eff;
    logic [CCMP_W-1:0]             col_inc;
    logic [RCMP_W-1:0]             row_inc;
    logic [pdug_pkg::LUMA_PROD_W-1:0] luma_sum;
    logic [pdug_pkg::CHAN_W-1:0]   luma;
    logic [pdug_pkg::CHAN_W-1:0]   sel_red;
    logic [pdug_pkg::CHAN_W-1:0]   sel_green;
    logic [pdug_pkg::CHAN_W-1:0]   sel_blue;

    // ------------------------------------------------------------------
    // Handshake: load the output register whenever it is empty or its
    // transaction leaves; free the hold register on the fourth load.
    // ------------------------------------------------------------------
    assign out_load  = hold_valid_reg && (!out_valid_reg || !out_stall);
    assign hold_done = out_load && (phase_reg == pdug_pkg::PHASE_LAST);
    assign in_stall  = hold_valid_reg && !hold_done;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (hold_done)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Raster position: clamp the sizes to 1..MAX, advance after each
    // accepted pixel and wrap at the end of a row and of the image.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = CCMP_W'(1);
        end
        else if (CCMP_W'(cols_reg) > CCMP_W'(MAX_COLS))
        begin
            cols_eff = CCMP_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = CCMP_W'(cols_reg);
        end

        if (rows_reg == '0)
        begin
            rows_eff = RCMP_W'(1);
        end
        else if (RCMP_W'(rows_reg) > RCMP_W'(MAX_ROWS))
        begin
            rows_eff = RCMP_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RCMP_W'(rows_reg);
        end
    end

    assign col_inc = CCMP_W'(col_pos_reg) + CCMP_W'(1);
    assign row_inc = RCMP_W'(row_pos_reg) + RCMP_W'(1);

    always_comb
    begin
        col_pos_next = col_inc[COL_W-1:0];
        row_pos_next = row_pos_reg;
        if (col_inc >= cols_eff)
        begin
            col_pos_next = '0;
            if (row_inc >= rows_eff)
            begin
                row_pos_next = '0;
            end
            else
            begin
                row_pos_next = row_inc[ROW_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Luma from the held pixel; constant weights reduce to shift-adds.
    // ------------------------------------------------------------------
    assign luma_sum = pdug_pkg::W_RED   * pdug_pkg::LUMA_PROD_W'(hold_red_reg)
                    + pdug_pkg::W_GREEN * pdug_pkg::LUMA_PROD_W'(hold_green_reg)
                    + pdug_pkg::W_BLUE  * pdug_pkg::LUMA_PROD_W'(hold_blue_reg);
    assign luma     = luma_sum[pdug_pkg::LUMA_PROD_W-1:pdug_pkg::LUMA_PROD_W-pdug_pkg::CHAN_W];

    assign sel_red   = gray_reg ? luma : hold_red_reg;
    assign sel_green = gray_reg ? luma : hold_green_reg;
    assign sel_blue  = gray_reg ? luma : hold_blue_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= pdug_pkg::SIZE_W'(1);
            rows_reg <= pdug_pkg::SIZE_W'(1);
            gray_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdug_pkg::REG_IMAGE_COLS:  cols_reg <= cfg_data;
                pdug_pkg::REG_IMAGE_ROWS:  rows_reg <= cfg_data;
                pdug_pkg::REG_GRAY_ENABLE: gray_reg <= cfg_data[0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            hold_valid_reg <= 1'b0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (in_accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
            if (out_load)
            begin
                phase_reg <= phase_reg + pdug_pkg::PHASE_W'(1);
            end
        end
    end

    // capture the pixel and its source position
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_red_reg   <= red;
            hold_green_reg <= green;
            hold_blue_reg  <= blue;
            hold_col_reg   <= col_pos_reg;
            hold_row_reg   <= row_pos_reg;
        end
    end

    // destination coordinate is twice the source one plus the block offset
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= pdug_pkg::COORD_W'({hold_row_reg, phase_reg[1]});
            out_col_reg   <= pdug_pkg::COORD_W'({hold_col_reg, phase_reg[0]});
            out_red_reg   <= sel_red;
            out_green_reg <= sel_green;
            out_blue_reg  <= sel_blue;
            out_last_reg  <= (phase_reg == pdug_pkg::PHASE_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign block_last = out_last_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // Index with no register behind it; writes there must be ignored
    localparam logic [pdug_pkg::INDEX_W-1:0] REG_SPARE = 2'd3;

    // Luma weights, 16-bit fixed point
    localparam int unsigned LUMA_R = 13933;
    localparam int unsigned LUMA_G = 46871;
    localparam int unsigned LUMA_B = 4732;

    localparam int SIZE_TOP       = 8191;  // all-ones size word
    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
    localparam int RANDOM_PIXELS  = 85;

    typedef struct packed {
        logic [pdug_pkg::COORD_W-1:0] row;
        logic [pdug_pkg::COORD_W-1:0] col;
        logic [pdug_pkg::CHAN_W-1:0]  red;
        logic [pdug_pkg::CHAN_W-1:0]  green;
        logic [pdug_pkg::CHAN_W-1:0]  blue;
        logic                         last;
    } dst_pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         cfg_we = 1'b0;
    logic [pdug_pkg::INDEX_W-1:0] cfg_index = '0;
    logic [pdug_pkg::SIZE_W-1:0]  cfg_data = '0;

    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [pdug_pkg::CHAN_W-1:0] red = '0;
    logic [pdug_pkg::CHAN_W-1:0] green = '0;
    logic [pdug_pkg::CHAN_W-1:0] blue = '0;

    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [pdug_pkg::COORD_W-1:0] out_row;
    logic [pdug_pkg::COORD_W-1:0] out_col;
    logic [pdug_pkg::CHAN_W-1:0]  out_red;
    logic [pdug_pkg::CHAN_W-1:0]  out_green;
    logic [pdug_pkg::CHAN_W-1:0]  out_blue;
    logic                         block_last;

    // Shadow of the block: configuration and raster position
    logic [pdug_pkg::SIZE_W-1:0] size_cols = 13'd1;
    logic [pdug_pkg::SIZE_W-1:0] size_rows = 13'd1;
    logic                        gray_on = 1'b0;
    logic [11:0]                 pos_row = '0;
    logic [11:0]                 pos_col = '0;

    dst_pixel_t pending_outputs[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    // Idling controls: per-transaction random gaps on each side
    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int sink_hold_cycles = 0;

    pixel_double_upscale_gray u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .block_last (block_last)
    );

    always #5 clk = ~clk;

    // A size of zero behaves as one; anything past the limit saturates
    function automatic int clamp_dim(input logic [pdug_pkg::SIZE_W-1:0] v, input int lim);
        if (v == 0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    // Queue the 2x2 destination block for one accepted source pixel,
    // then advance the raster position with wrap at row and image end.
    task automatic upscale_pixel(input logic [pdug_pkg::CHAN_W-1:0] r, g, b);
        dst_pixel_t  px;
        int unsigned luma_sum;
        logic [pdug_pkg::CHAN_W-1:0] ch_r, ch_g, ch_b;
        ch_r = r;
        ch_g = g;
        ch_b = b;
        if (gray_on)
        begin
            luma_sum = LUMA_R * r + LUMA_G * g + LUMA_B * b;
            ch_r = luma_sum[23:16];
            ch_g = luma_sum[23:16];
            ch_b = luma_sum[23:16];
        end
        for (int dy = 0; dy < 2; dy++)
        begin
            for (int dx = 0; dx < 2; dx++)
            begin
                px.row   = {pos_row, dy[0]};
                px.col   = {pos_col, dx[0]};
                px.red   = ch_r;
                px.green = ch_g;
                px.blue  = ch_b;
                px.last  = (dy == 1 && dx == 1);
                pending_outputs.push_back(px);
            end
        end
        if (int'(pos_col) + 1 >= clamp_dim(size_cols, pdug_pkg::MAX_COLS_DEF))
        begin
            pos_col = '0;
            if (int'(pos_row) + 1 >= clamp_dim(size_rows, pdug_pkg::MAX_ROWS_DEF))
                pos_row = '0;
            else
                pos_row = pos_row + 1'b1;
        end
        else
            pos_col = pos_col + 1'b1;
    endtask

    // Offer one source pixel; hold it until the block accepts it.
    // Left at a rising edge, so a back-to-back pixel keeps
    // valid high without a second assignment in the same step.
    task automatic send_pixel(input logic [pdug_pkg::CHAN_W-1:0] r, g, b);
        int gap;
        gap = src_idle ? $urandom_range(0, 17) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do @(posedge clk); while (in_stall);
        upscale_pixel(r, g, b);
    endtask

    // Drop valid and wait until every queued destination pixel is out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register while the block is idle and mirror it
    task automatic write_reg(input logic [pdug_pkg::INDEX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= pdug_pkg::SIZE_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pdug_pkg::REG_IMAGE_COLS:  size_cols = pdug_pkg::SIZE_W'(value);
            pdug_pkg::REG_IMAGE_ROWS:  size_rows = pdug_pkg::SIZE_W'(value);
            pdug_pkg::REG_GRAY_ENABLE: gray_on   = value[0];
            default:                   ;
        endcase
    endtask

    task automatic set_image(input int cols, input int rows, input bit gray);
        write_reg(pdug_pkg::REG_IMAGE_COLS, cols);
        write_reg(pdug_pkg::REG_IMAGE_ROWS, rows);
        write_reg(pdug_pkg::REG_GRAY_ENABLE, gray);
    endtask

    // Random channel value, biased toward the rails
    function automatic logic [pdug_pkg::CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return pdug_pkg::CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int rand_size(input int hi);
        if ($urandom_range(0, 7) != 0)
            return $urandom_range(1, hi);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return pdug_pkg::MAX_COLS_DEF;
            default: return SIZE_TOP;
        endcase
    endfunction

    task automatic note_failure(input string reason, input dst_pixel_t want, got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected row %0d col %0d rgb %0d/%0d/%0d last %0b",
                     $realtime, reason,
                     want.row, want.col, want.red, want.green, want.blue, want.last);
            $display("    got row %0d col %0d rgb %0d/%0d/%0d last %0b",
                     got.row, got.col, got.red, got.green, got.blue, got.last);
        end
    endtask

    // Check each output transaction against the oldest queued pixel
    always @(posedge clk)
    begin
        dst_pixel_t got;
        dst_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.row   = out_row;
            got.col   = out_col;
            got.red   = out_red;
            got.green = out_green;
            got.blue  = out_blue;
            got.last  = block_last;
            if (pending_outputs.size() == 0)
                note_failure("unexpected output", '0, got);
            else
            begin
                want = pending_outputs.pop_front();
                if (got !== want)
                    note_failure("output mismatch", want, got);
            end
        end
    end

    // Receiver: draw a stall before each output transaction; a requested
    // long hold replaces one draw so the block backs up into its input.
    initial
    begin : sink
        int stall_len;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                stall_len = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            else
                stall_len = sink_idle ? $urandom_range(0, 17) : 0;
            @(negedge clk);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pixel_double_upscale_gray verification failed");
            $finish;
        end
    end

    // Reset sizes are 1x1: every pixel lands on the same block
    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        settle();
    endtask

    // Color copy over a whole 2x2 image plus one pixel past the wrap
    task automatic test_color_copy();
        set_image(2, 2, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h0F);
        send_pixel(8'hAA, 8'h55, 8'hF0);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h12, 8'h34, 8'h56);
        settle();
    endtask

    // Luma on all channels: full white must reach 255, single channels
    // exercise each weight alone
    task automatic test_gray();
        set_image(3, 1, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        settle();
    endtask

    // Zero sizes behave as one
    task automatic test_zero_size();
        set_image(0, 0, 1'b0);
        send_pixel(8'h80, 8'h01, 8'h7F);
        send_pixel(8'h01, 8'h80, 8'hFE);
        settle();
    endtask

    // Writes to the spare index leave every register alone
    task automatic test_spare_register();
        set_image(2, 1, 1'b1);
        write_reg(REG_SPARE, SIZE_TOP);
        write_reg(REG_SPARE, 0);
        send_pixel(8'h3C, 8'hC3, 8'h99);
        send_pixel(8'hC3, 8'h3C, 8'h66);
        settle();
    endtask

    // Shrink the width under the current position: the next pixel still
    // goes out at the old column, then the position wraps.
    task automatic test_resize_mid_image();
        set_image(3, 2, 1'b0);
        repeat (4) send_pixel(rand_chan(), rand_chan(), rand_chan());
        settle();
        write_reg(pdug_pkg::REG_IMAGE_COLS, 1);
        repeat (2) send_pixel(rand_chan(), rand_chan(), rand_chan());
        settle();
    endtask

    // Oversize width: the row keeps running past small columns, then a
    // one-pixel width forces the wrap from a column beyond it.
    task automatic test_oversize_width();
        set_image(SIZE_TOP, 2, 1'b0);
        repeat (4) send_pixel(rand_chan(), rand_chan(), rand_chan());
        settle();
        write_reg(pdug_pkg::REG_IMAGE_COLS, 1);
        repeat (2) send_pixel(rand_chan(), rand_chan(), rand_chan());
        settle();
    endtask

    // Hold the receiver off while the sender keeps offering pixels
    task automatic test_backpressure();
        set_image(4, 3, 1'b1);
        src_idle = 1'b0;
        sink_hold_cycles = 80;
        repeat (6) send_pixel(rand_chan(), rand_chan(), rand_chan());
        settle();
        src_idle = 1'b1;
    endtask

    // Random phases: new sizes and gray mode each phase, mostly small
    // images so wraps come often; idling on or off per side per phase.
    task automatic test_random_stream();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            set_image(rand_size(6), rand_size(4), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_SPARE, $urandom_range(0, SIZE_TOP));
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            burst = $urandom_range(5, 25);
            repeat (burst) send_pixel(rand_chan(), rand_chan(), rand_chan());
            settle();
            sent += burst;
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_color_copy();
        test_gray();
        test_zero_size();
        test_spare_register();
        test_resize_mid_image();
        test_oversize_width();
        test_backpressure();
        test_random_stream();

        settle();
        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("pixel_double_upscale_gray verification clean");
        else
            $display("pixel_double_upscale_gray verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/pdug_pkg.sv
design/pixel_double_upscale_gray.sv
test/testbench.sv
